/* sv/e2q_pkg.sv */
// ---------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and the arctangent table for the Euler-angle to
// quaternion pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package e2q_pkg;

  localparam int AngleW      = 18;
  localparam int QuatW       = 16;
  localparam int CordicW     = 34;   // Q30 plus sign and growth headroom
  localparam int TrigW       = 22;   // Q20 cos/sin, range about +-1.0
  localparam int MaxIter     = 24;
  localparam int DefaultIter = 16;

  localparam logic signed [18:0] HalfTurnUnits = 19'sd184320;
  localparam logic signed [18:0] QuadUnits     = 19'sd46080;
  localparam logic signed [18:0] OctUnits      = 19'sd23040;
  localparam logic signed [CordicW-1:0] GainQ30 = 34'sd652032874;

  // Arctangent of 1 (pi/4) in Q30; stage B scales the residual magnitude by it.
  localparam logic [63:0] Atan0Q30 = 64'd843314857;

  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    trig_t c;
    trig_t s;
  } cs_t;

  function automatic logic signed [CordicW-1:0] atan_q30(input int i);
    logic signed [CordicW-1:0] v;
    v = '0;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage : e2q_pkg
`default_nettype wire

/* sv/e2q_halfsc.sv */
// ---------------------------------------------------------------------------
// e2q_halfsc
// Pipelined cosine and sine of a half angle: range reduction, radian
// scaling, one CORDIC micro-rotation per stage, quadrant fix and rounding.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_halfsc import e2q_pkg::*; #(
  parameter int Iter = DefaultIter
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [AngleW-1:0] angle,
  output cs_t                           cs
);

  localparam int N = (Iter < MaxIter) ? Iter : MaxIter;

  // Stage A: wrap to [0,184320), split into quadrant and residual.
  logic signed [18:0] u;
  logic signed [18:0] r_a;
  logic [1:0]         q_a;
  logic signed [18:0] v;
  always_comb begin
    u = 19'(angle);
    if (u < 0) u = u + HalfTurnUnits;
    v = u + OctUnits;
    if (v >= 19'sd184320) begin
      q_a = 2'd0; r_a = u - 19'sd184320;
    end else if (v >= 19'sd138240) begin
      q_a = 2'd3; r_a = u - 19'sd138240;
    end else if (v >= 19'sd92160) begin
      q_a = 2'd2; r_a = u - 19'sd92160;
    end else if (v >= QuadUnits) begin
      q_a = 2'd1; r_a = u - QuadUnits;
    end else begin
      q_a = 2'd0; r_a = u;
    end
  end

  logic [14:0] mag_b;
  logic        neg_b;
  logic [1:0]  q_b;
  always_ff @(posedge clk) begin
    if (en) begin
      neg_b <= r_a < 0;
      mag_b <= (r_a < 0) ? 15'(-r_a) : 15'(r_a);
      q_b   <= q_a;
    end
  end

  // Stage B: numerator mag*Atan0 + 11520 (at most 45 bits).
  logic [45:0] num_c;
  logic        neg_c;
  logic [1:0]  q_c;
  always_ff @(posedge clk) begin
    if (en) begin
      num_c <= 46'({31'd0, mag_b} * Atan0Q30[29:0]) + 46'd11520;
      neg_c <= neg_b;
      q_c   <= q_b;
    end
  end

  // Stage C: divide by 23040 = 512*45; shift by 9 then estimate the quotient
  // by 45 through a reciprocal. The estimate is exact or one too small.
  logic [36:0] n9;
  logic [67:0] prod;
  always_comb begin
    n9   = num_c[45:9];
    prod = {31'd0, n9} * 68'd1527099483; // floor(2^36/45)
  end

  logic [36:0] n9_d;
  logic [36:0] qe_d;
  logic        neg_d;
  logic [1:0]  q_d;
  always_ff @(posedge clk) begin
    if (en) begin
      n9_d  <= n9;
      qe_d  <= 37'(prod >> 36);
      neg_d <= neg_c;
      q_d   <= q_c;
    end
  end

  // Stage D: one compare and subtract fixes the estimate.
  logic [36:0] rem;
  logic [30:0] quo;
  always_comb begin
    rem = n9_d - 37'(qe_d * 37'd45);
    quo = (rem >= 37'd45) ? 31'(qe_d + 37'd1) : 31'(qe_d);
  end

  logic signed [CordicW-1:0] z_s [0:N];
  logic signed [CordicW-1:0] x_s [0:N];
  logic signed [CordicW-1:0] y_s [0:N];
  logic [1:0]                q_s [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      z_s[0] <= neg_d ? -CordicW'(signed'({1'b0, quo})) : CordicW'(signed'({1'b0, quo}));
      x_s[0] <= GainQ30;
      y_s[0] <= '0;
      q_s[0] <= q_d;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [CordicW-1:0] dx, dy;
    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - atan_q30(i);
        end else begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + atan_q30(i);
        end
        q_s[i+1] <= q_s[i];
      end
    end
  end

  // Quadrant rotation and rounding to Q20.
  logic signed [CordicW-1:0] c_f, s_f, c_r, s_r;
  always_comb begin
    case (q_s[N])
      2'd0:    begin c_f = x_s[N];  s_f = y_s[N];  end
      2'd1:    begin c_f = -y_s[N]; s_f = x_s[N];  end
      2'd2:    begin c_f = -x_s[N]; s_f = -y_s[N]; end
      default: begin c_f = y_s[N];  s_f = -x_s[N]; end
    endcase
    c_r = (c_f + CordicW'(512)) >>> 10;
    s_r = (s_f + CordicW'(512)) >>> 10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs.c <= TrigW'(c_r);
      cs.s <= TrigW'(s_r);
    end
  end

endmodule : e2q_halfsc
`default_nettype wire

/* sv/e2q_combine.sv */
// ---------------------------------------------------------------------------
// e2q_combine
// Triple products of the half-angle cosines and sines, summed, rounded to
// Q1.15 and saturated. Three register stages.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_combine import e2q_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire cs_t                     r,
  input  wire cs_t                     p,
  input  wire cs_t                     y,
  output logic signed [QuatW-1:0]      qw,
  output logic signed [QuatW-1:0]      qx,
  output logic signed [QuatW-1:0]      qy,
  output logic signed [QuatW-1:0]      qz
);

  localparam int PW = 2 * TrigW;  // Q40 pair product
  localparam int TW = 3 * TrigW;  // Q60 triple product

  // Stage 1: yaw-pitch pair products, roll delayed.
  logic signed [PW-1:0] cycp, sysp, sycp, cysp;
  cs_t r1;
  always_ff @(posedge clk) begin
    if (en) begin
      cycp <= y.c * p.c;
      sysp <= y.s * p.s;
      sycp <= y.s * p.c;
      cysp <= y.c * p.s;
      r1   <= r;
    end
  end

  // Stage 2: triple products.
  logic signed [TW-1:0] t0, t1, t2, t3, t4, t5, t6, t7;
  always_ff @(posedge clk) begin
    if (en) begin
      t0 <= cycp * r1.c;  t1 <= sysp * r1.s;
      t2 <= cycp * r1.s;  t3 <= sysp * r1.c;
      t4 <= sycp * r1.s;  t5 <= cysp * r1.c;
      t6 <= sycp * r1.c;  t7 <= cysp * r1.s;
    end
  end

  function automatic logic signed [QuatW-1:0] to_q15(input logic signed [TW:0] v);
    logic signed [TW:0] s;
    s = (v + (TW+1)'(64'sh1000_0000_0000)) >>> 45;
    if (s > 32767)       return 16'sh7fff;
    else if (s < -32768) return 16'sh8000;
    else                 return QuatW'(s);
  endfunction

  // Stage 3: sums, rounding, saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      qw <= to_q15((TW+1)'(t0) + (TW+1)'(t1));
      qx <= to_q15((TW+1)'(t2) - (TW+1)'(t3));
      qy <= to_q15((TW+1)'(t4) + (TW+1)'(t5));
      qz <= to_q15((TW+1)'(t6) - (TW+1)'(t7));
    end
  end

endmodule : e2q_combine
`default_nettype wire

/* sv/euler_to_quaternion.sv */
// ---------------------------------------------------------------------------
// euler_to_quaternion
// Converts roll, pitch and yaw angles in 1/256-degree units to a ZYX unit quaternion.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         tdata: roll_deg[17:0], pitch_deg[35:18], yaw_deg[53:36]
// m_axis    out        tdata: quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
//
// One item is accepted every cycle unless the output stalls. The pipeline
// registers are, in order: four for range reduction and radian scaling, one per
// CORDIC micro-rotation, one for the quadrant fix and three for the product tree.
// The whole pipeline advances together whenever the output register is empty
// or being drained, so a stall freezes every stage and loses nothing.
// Reset clears only the valid bits; data registers are not reset.
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; #(
  parameter int CORDIC_ITERATIONS = DefaultIter
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // roll_deg, pitch_deg, yaw_deg, zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);

  localparam int NIt = (CORDIC_ITERATIONS < MaxIter) ? CORDIC_ITERATIONS : MaxIter;
  // halfsc: 3 reduction + N rotations + 1 fix, plus one seed stage; combine: 3.
  localparam int Lat = NIt + 8;

  logic en;
  logic [Lat-1:0] vld;

  assign en            = !vld[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end

  cs_t cs_r, cs_p, cs_y;

  e2q_halfsc #(.Iter(CORDIC_ITERATIONS)) u_roll (
    .clk(clk), .en(en), .angle(signed'(s_axis_tdata[17:0])), .cs(cs_r));
  e2q_halfsc #(.Iter(CORDIC_ITERATIONS)) u_pitch (
    .clk(clk), .en(en), .angle(signed'(s_axis_tdata[35:18])), .cs(cs_p));
  e2q_halfsc #(.Iter(CORDIC_ITERATIONS)) u_yaw (
    .clk(clk), .en(en), .angle(signed'(s_axis_tdata[53:36])), .cs(cs_y));

  logic signed [QuatW-1:0] qw, qx, qy, qz;

  e2q_combine u_comb (
    .clk(clk), .en(en), .r(cs_r), .p(cs_p), .y(cs_y),
    .qw(qw), .qx(qx), .qy(qy), .qz(qz));

  assign m_axis_tdata = {qz, qy, qx, qw};

endmodule : euler_to_quaternion
`default_nettype wire

/* sv/e2q_checker.sv */
// ---------------------------------------------------------------------------
// e2q_checker
// Port-level checks on the Euler-angle to quaternion converter.
// ---------------------------------------------------------------------------
`default_nettype none
module e2q_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata
);

  // The pipeline only stalls when its output is held.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule : e2q_checker

bind euler_to_quaternion e2q_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata));
`default_nettype wire

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Drives roll/pitch/yaw items into euler_to_quaternion and checks every
// quaternion against a bit-exact CORDIC predictor, under random idling on both
// sides and one long output hold-off that backs up the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import e2q_pkg::*;

  localparam int Iter = DefaultIter;
  localparam int Latency = Iter + 8;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic signed [15:0] w;
  } quat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // roll_deg[17:0], pitch_deg[35:18], yaw_deg[53:36]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // quat_w, quat_x, quat_y, quat_z

  // Idling control: the sender and receiver each skip about 22% of cycles
  // unless the quiet flag is set; the hold flag freezes the receiver outright.
  logic no_idle = 1'b0;
  logic sink_hold = 1'b0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  quat_t pending_quats[$];

  euler_to_quaternion #(.CORDIC_ITERATIONS(Iter)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  // Cosine and sine of the half angle, both Q20.
  task automatic half_angle_trig(input logic [17:0] raw,
                                 output logic signed [63:0] c20,
                                 output logic signed [63:0] s20);
    logic signed [63:0] u, q, r, mag, ang, x, y, dx, dy, c, s;
    u = {{46{raw[17]}}, raw};
    if (u < 0) u = u + 184320;
    q = (u + 23040) / 46080;
    r = u - q * 46080;
    q = q & 3;
    mag = (r < 0) ? -r : r;
    ang = (mag * 64'sd843314857 + 11520) / 23040;
    if (r < 0) ang = -ang;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < Iter && i < MaxIter; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (ang >= 0) begin
        x = x - dx; y = y + dy; ang = ang - 64'(atan_q30(i));
      end else begin
        x = x + dx; y = y - dy; ang = ang + 64'(atan_q30(i));
      end
    end
    case (q)
      0: begin c = x;  s = y;  end
      1: begin c = -y; s = x;  end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    c20 = floor_shift(c + 512, 10);
    s20 = floor_shift(s + 512, 10);
  endtask

  function automatic logic signed [15:0] round_q15(logic signed [63:0] q60);
    logic signed [63:0] v;
    v = floor_shift(q60 + (64'sd1 <<< 44), 45);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_quat(input logic [17:0] roll, input logic [17:0] pitch,
                              input logic [17:0] yaw, output quat_t qt);
    logic signed [63:0] cr, sr, cp, sp, cy, sy;
    half_angle_trig(roll, cr, sr);
    half_angle_trig(pitch, cp, sp);
    half_angle_trig(yaw, cy, sy);
    qt.w = round_q15(cy * cp * cr + sy * sp * sr);
    qt.x = round_q15(cy * cp * sr - sy * sp * cr);
    qt.y = round_q15(sy * cp * sr + cy * sp * cr);
    qt.z = round_q15(sy * cp * cr - cy * sp * sr);
  endtask

  // Offer one item, possibly after random idle cycles, and wait for acceptance.
  // The valid stays high straight into the next item when there is no gap.
  task automatic send_angles(input logic [17:0] roll, input logic [17:0] pitch,
                             input logic [17:0] yaw);
    quat_t qt;
    while (!no_idle && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_quat(roll, pitch, yaw, qt);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, yaw, pitch, roll};
    do @(posedge clk); while (!s_axis_tready);
    pending_quats.push_back(qt);
  endtask

  task automatic release_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random ready, frozen while a hold-off is active.
  always @(posedge clk) begin
    if (rst || sink_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= no_idle || ($urandom_range(99) >= 22);
  end

  // Result checker: compares each accepted quaternion to the oldest prediction.
  always @(posedge clk) begin
    quat_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected quaternion %h", $realtime, got);
        mismatches++;
      end else begin
        want = pending_quats.pop_front();
        if (got.w !== want.w) begin
          $display("%0t: quat_w expected %0d actual %0d", $realtime, want.w, got.w);
          mismatches++;
        end
        if (got.x !== want.x) begin
          $display("%0t: quat_x expected %0d actual %0d", $realtime, want.x, got.x);
          mismatches++;
        end
        if (got.y !== want.y) begin
          $display("%0t: quat_y expected %0d actual %0d", $realtime, want.y, got.y);
          mismatches++;
        end
        if (got.z !== want.z) begin
          $display("%0t: quat_z expected %0d actual %0d", $realtime, want.z, got.z);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [17:0] random_angle();
    case ($urandom_range(9))
      0: return 18'($urandom);                                 // any pattern
      1: return 18'(($urandom_range(8) - 4) * 11520);          // multiples of 45 deg
      2: return 18'(($urandom_range(16) - 8) * 11520 + $urandom_range(6) - 3);
      default: return 18'($urandom_range(184320) - 92160);     // nominal range
    endcase
  endfunction

  // Extremes, quadrant and octant edges, saturation at exactly +1.0.
  task automatic test_directed();
    logic [17:0] edges [16] = '{18'd0, 18'sd92160, -18'sd92160, 18'sd23040,
      -18'sd23040, 18'sd46080, 18'sd69120, -18'sd46080, 18'sd131071,
      -18'sd131072, 18'sd11520, 18'sd23039, -18'sd23041, 18'sd1, -18'sd1,
      18'sd46079};
    for (int i = 0; i < 16; i++) send_angles(edges[i], edges[(i + 5) % 16],
                                              edges[(i + 11) % 16]);
    send_angles(18'd0, 18'd0, 18'd0);
    send_angles(18'sd92160, 18'sd92160, 18'sd92160);
    send_angles(18'h15555, 18'h2AAAA, 18'h3FFFF);
    send_angles(18'h2AAAA, 18'h15555, 18'h00000);
    release_sender();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      no_idle <= (i >= count / 3 && i < count / 2);
      send_angles(random_angle(), random_angle(), random_angle());
    end
    no_idle <= 1'b0;
    release_sender();
  endtask

  // Output held off for a long stretch while items keep being offered.
  task automatic test_backpressure();
    fork
      begin
        sink_hold <= 1'b1;
        repeat (3 * Latency + 40) @(posedge clk);
        sink_hold <= 1'b0;
      end
      begin
        no_idle <= 1'b1;
        for (int i = 0; i < 2 * Latency + 20; i++)
          send_angles(random_angle(), random_angle(), random_angle());
        no_idle <= 1'b0;
        release_sender();
      end
    join
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(440);
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
sv/e2q_pkg.sv
sv/e2q_halfsc.sv
sv/e2q_combine.sv
sv/euler_to_quaternion.sv
sv/e2q_checker.sv
sim/testbench.sv
